>>> src/tss_pkg.sv
package tss_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int LENGTH_W = 16;
	localparam int SLOT_W   = 4;
	localparam int STEP_W   = 16;
	localparam int QUANT_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic MODE_FCFS = 1'b0;
	localparam logic MODE_RR   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_EXEC,
		ST_EMIT
	} state_t;

endpackage

>>> src/time_slice_process_scheduler_top.sv
// Time-slice process scheduler.
// Input channel (in_valid/in_ready, cmd, length): cmd add appends a process of the given
// length to the next free slot; cmd tick runs one instruction of the chosen process.
// Output channel (out_valid/out_ready): exactly one result per input item, in order.
// Configuration (cfg_we, cfg_index, cfg_data): index 0 selects first-come (0) or round
// robin (1); index 1 sets the quantum, where zero acts as one. Write only when idle.
// Counts live in a single synchronous RAM with a registered read port; the runnable
// flag of every slot is held in flip-flops so the search never touches the RAM.
// An add is accepted in IDLE and its result is loaded into the output register in EMIT.
// A tick that continues an open round-robin slice steps through accept, RAM read, update
// and load output. Any other tick first scans the runnable flags one slot per cycle,
// visiting at most the number of filled slots; a tick on an empty table skips the scan
// and the RAM and goes straight to loading the output.
// The next item is accepted while a result still waits in the output register; the
// block only holds a new result back while the receiver has not taken the previous one.
// Reset empties the table, selects first-come mode with a quantum of one and clears
// the output valid flag; the RAM itself is not cleared, since only written slots are read.
module time_slice_process_scheduler_top #(
	parameter int SLOTS      = tss_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = tss_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [tss_pkg::LENGTH_W-1:0]   length,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic [tss_pkg::SLOT_W-1:0]     slot,
	output logic [tss_pkg::STEP_W-1:0]     step_index,
	output logic                           done_now,
	input  logic                           cfg_we,
	input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tss_pkg::QUANT_W-1:0]    cfg_data
);

	localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int USED_BITS = $clog2(SLOTS + 1);
	localparam int ENTRY_W   = 2 * COUNT_BITS;
	localparam int QW        = tss_pkg::QUANT_W;

	tss_pkg::state_t state_q, state_d;

	// Slot table: {total, executed}.
	logic [ENTRY_W-1:0]    mem [SLOTS];
	logic [ENTRY_W-1:0]    mem_rd_q;
	logic                  mem_we;
	logic [SLOT_BITS-1:0]  mem_wa;
	logic [ENTRY_W-1:0]    mem_wd;

	logic [SLOTS-1:0]      runnable_q;
	logic [USED_BITS-1:0]  used_q;
	logic [SLOT_BITS-1:0]  cur_q;
	logic [QW-1:0]         slice_used_q;
	logic                  slice_active_q;
	logic                  mode_q;
	logic [QW-1:0]         quantum_q;

	logic [SLOT_BITS-1:0]  scan_q;
	logic [USED_BITS-1:0]  left_q;
	logic [SLOT_BITS-1:0]  slot_q;

	logic                  res_acc_q;
	logic [tss_pkg::SLOT_W-1:0] res_slot_q;
	logic [tss_pkg::STEP_W-1:0] res_step_q;
	logic                  res_done_q;

	logic                  out_valid_q;
	logic                  out_acc_q;
	logic [tss_pkg::SLOT_W-1:0] out_slot_q;
	logic [tss_pkg::STEP_W-1:0] out_step_q;
	logic                  out_done_q;

	logic                  in_xfer;
	logic                  emit_go;
	logic [QW-1:0]         q_eff;
	logic                  cur_in_range;
	logic                  rr_keep;
	logic                  full;
	logic [COUNT_BITS-1:0] add_len;
	logic [31:0]           len_ext;
	logic [USED_BITS-1:0]  scan_inc;
	logic [USED_BITS-1:0]  slot_inc;
	logic [COUNT_BITS-1:0] ex_total;
	logic [COUNT_BITS-1:0] ex_run;
	logic [COUNT_BITS-1:0] ex_run_n;
	logic                  ex_fin;
	logic [QW-1:0]         ex_su_n;
	logic [31:0]           ex_run_ext;
	logic [7:0]            slot_ext;
	logic [7:0]            used_ext;

	assign in_xfer      = in_valid && in_ready;
	assign q_eff        = (quantum_q == '0) ? QW'(1) : quantum_q;
	assign cur_in_range = USED_BITS'(cur_q) < used_q;
	assign rr_keep      = (mode_q == tss_pkg::MODE_RR) && slice_active_q
	                      && (slice_used_q < q_eff) && cur_in_range && runnable_q[cur_q];
	assign full         = (used_q == USED_BITS'(SLOTS));
	assign len_ext      = 32'(length);
	assign add_len      = len_ext[COUNT_BITS-1:0];
	assign scan_inc     = USED_BITS'(scan_q) + USED_BITS'(1);
	assign slot_inc     = USED_BITS'(slot_q) + USED_BITS'(1);

	assign ex_total   = mem_rd_q[ENTRY_W-1:COUNT_BITS];
	assign ex_run     = mem_rd_q[COUNT_BITS-1:0];
	assign ex_run_n   = ex_run + COUNT_BITS'(1);
	assign ex_fin     = (ex_run_n == ex_total);
	assign ex_su_n    = slice_used_q + QW'(1);
	assign ex_run_ext = 32'(ex_run);
	assign slot_ext   = 8'(slot_q);
	assign used_ext   = 8'(used_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tss_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (cmd == tss_pkg::CMD_ADD) begin
						state_d = tss_pkg::ST_EMIT;
					end else if (rr_keep) begin
						state_d = tss_pkg::ST_READ;
					end else if (used_q == '0) begin
						state_d = tss_pkg::ST_EMIT;
					end else begin
						state_d = tss_pkg::ST_SCAN;
					end
				end
			end
			tss_pkg::ST_SCAN: begin
				if (runnable_q[scan_q]) begin
					state_d = tss_pkg::ST_READ;
				end else if (left_q == USED_BITS'(1)) begin
					state_d = tss_pkg::ST_EMIT;
				end
			end
			tss_pkg::ST_READ: state_d = tss_pkg::ST_EXEC;
			tss_pkg::ST_EXEC: state_d = tss_pkg::ST_EMIT;
			tss_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = tss_pkg::ST_IDLE;
				end
			end
			default: state_d = tss_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		in_ready = 1'b0;
		emit_go  = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = slot_q;
		mem_wd   = {ex_total, ex_run_n};
		case (state_q)
			tss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && cmd == tss_pkg::CMD_ADD && !full) begin
					mem_we = 1'b1;
					mem_wa = SLOT_BITS'(used_q);
					mem_wd = {add_len, {COUNT_BITS{1'b0}}};
				end
			end
			tss_pkg::ST_EXEC: mem_we = 1'b1;
			tss_pkg::ST_EMIT: emit_go = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == tss_pkg::ST_READ) begin
			mem_rd_q <= mem[slot_q];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tss_pkg::ST_IDLE;
			runnable_q     <= '0;
			used_q         <= '0;
			cur_q          <= '0;
			slice_used_q   <= '0;
			slice_active_q <= 1'b0;
			mode_q         <= tss_pkg::MODE_FCFS;
			quantum_q      <= QW'(1);
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					tss_pkg::REG_MODE:    mode_q <= cfg_data[0];
					tss_pkg::REG_QUANTUM: quantum_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				if (cmd == tss_pkg::CMD_ADD) begin
					if (!full) begin
						runnable_q[SLOT_BITS'(used_q)] <= (add_len != '0);
						used_q <= used_q + USED_BITS'(1);
					end
				end else if (mode_q == tss_pkg::MODE_RR && !rr_keep) begin
					slice_active_q <= 1'b0;
				end
			end
			if (state_q == tss_pkg::ST_SCAN && runnable_q[scan_q]
			    && mode_q == tss_pkg::MODE_RR) begin
				cur_q          <= scan_q;
				slice_used_q   <= '0;
				slice_active_q <= 1'b1;
			end
			if (state_q == tss_pkg::ST_EXEC) begin
				if (ex_fin) begin
					runnable_q[slot_q] <= 1'b0;
				end
				if (mode_q == tss_pkg::MODE_RR) begin
					if (ex_fin || ex_su_n >= q_eff) begin
						slice_active_q <= 1'b0;
						slice_used_q   <= '0;
						cur_q <= (slot_inc < used_q) ? SLOT_BITS'(slot_inc) : '0;
					end else begin
						slice_used_q <= ex_su_n;
					end
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_acc_q  <= 1'b0;
			res_slot_q <= '0;
			res_step_q <= '0;
			res_done_q <= 1'b0;
			if (cmd == tss_pkg::CMD_ADD) begin
				if (!full) begin
					res_acc_q  <= 1'b1;
					res_slot_q <= used_ext[tss_pkg::SLOT_W-1:0];
				end
			end else begin
				slot_q <= cur_q;
				left_q <= used_q;
				if (mode_q == tss_pkg::MODE_RR && cur_in_range) begin
					scan_q <= cur_q;
				end else begin
					scan_q <= '0;
				end
			end
		end
		if (state_q == tss_pkg::ST_SCAN) begin
			if (runnable_q[scan_q]) begin
				slot_q <= scan_q;
			end else begin
				scan_q <= (scan_inc == used_q) ? '0 : SLOT_BITS'(scan_inc);
				left_q <= left_q - USED_BITS'(1);
			end
		end
		if (state_q == tss_pkg::ST_EXEC) begin
			res_acc_q  <= 1'b1;
			res_slot_q <= slot_ext[tss_pkg::SLOT_W-1:0];
			res_step_q <= ex_run_ext[tss_pkg::STEP_W-1:0];
			res_done_q <= ex_fin;
		end
		if (emit_go) begin
			out_acc_q  <= res_acc_q;
			out_slot_q <= res_slot_q;
			out_step_q <= res_step_q;
			out_done_q <= res_done_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = out_acc_q;
	assign slot       = out_slot_q;
	assign step_index = out_step_q;
	assign done_now   = out_done_q;

endmodule

>>> src/tss_checker.sv
module tss_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          accepted,
	input logic [tss_pkg::SLOT_W-1:0]    slot,
	input logic [tss_pkg::STEP_W-1:0]    step_index,
	input logic                          done_now
);

	// A result waiting in the output register must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(slot)
		&& $stable(step_index) && $stable(done_now))
		else $error("result changed while stalled");

	// Only a tick that ran an instruction can report completion.
	a_done_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_now |-> accepted)
		else $error("done_now without accepted");

	// A refused add or an idle tick carries a zero slot and step index.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> slot == '0 && step_index == '0)
		else $error("non-zero fields on a refused item");

	// Items are worked on one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken before the first finished");

endmodule

bind time_slice_process_scheduler_top tss_checker u_tss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.accepted   (accepted),
	.slot       (slot),
	.step_index (step_index),
	.done_now   (done_now)
);
